### rtl/sgk_pkg.sv
// sgk_pkg: shared widths, coefficient tables, queue word and status types
// for the spheroidal gridding kernel; no dependencies
`timescale 1ns / 1ps

package sgk_pkg;

	localparam int IDX_W = 13;
	localparam int S_W = 4;
	localparam int O_W = 9;
	localparam int CFG_W = 9;
	localparam int DEN_W = 13;
	localparam int NUQ_W = 17;
	localparam int NUSQ_W = 33;
	localparam int ACC_W = 33;
	localparam int MAG_W = 32;
	localparam int AX_W = 32;
	localparam int VAL_W = 25;

	localparam int DEF_MAX_SUPPORT = 15;
	localparam int DEF_MAX_OVERSAMPLING = 256;
	localparam logic [S_W-1:0] SUPPORT_RESET = 4'd7;
	localparam logic [O_W-1:0] OVERSAMPLING_RESET = 9'd128;

	localparam logic REG_SUPPORT = 1'b0;
	localparam logic REG_OVERSAMPLING = 1'b1;

	localparam logic [NUQ_W-1:0] SEG_SPLIT = 17'd49152;
	localparam logic [NUSQ_W-1:0] ONE_Q32 = 33'h1_0000_0000;
	localparam logic [NUSQ_W-1:0] SEG0_OFFSET = 33'd2415919104;
	localparam logic [VAL_W-1:0] VAL_MAX = 25'd16777216;

	localparam int AXIS_LAT = 63;

	localparam int QUEUE_DEPTH = 4;
	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic             out_x;
		logic             out_y;
		logic [DEN_W-1:0] den;
		logic [DEN_W-1:0] ad_x;
		logic [DEN_W-1:0] ad_y;
	} sgk_item_t;

	typedef struct packed {
		logic [CNT_W-1:0] count;
		logic             full;
		logic             empty;
	} sgk_qstat_t;

	// numerator coefficients, Q30
	function automatic logic signed [ACC_W-1:0] num_coef(input logic seg, input logic [2:0] k);
		logic signed [ACC_W-1:0] c;
		unique case ({seg, k})
			4'b0_000: c = 33'sd88082725;
			4'b0_001: c = -33'sd391347219;
			4'b0_010: c = 33'sd674165984;
			4'b0_011: c = -33'sd572903648;
			4'b0_100: c = 33'sd248330285;
			4'b1_000: c = 33'sd4325632;
			4'b1_001: c = -33'sd39704482;
			4'b1_010: c = 33'sd109664688;
			4'b1_011: c = -33'sd129003208;
			4'b1_100: c = 33'sd68856637;
			default:  c = '0;
		endcase
		return c;
	endfunction

	// denominator coefficients, Q30
	function automatic logic signed [ACC_W-1:0] den_coef(input logic seg, input logic [1:0] k);
		logic signed [ACC_W-1:0] c;
		unique case ({seg, k})
			3'b0_00: c = 33'sd1073741824;
			3'b0_01: c = 33'sd881758719;
			3'b0_10: c = 33'sd223128168;
			3'b1_00: c = 33'sd1073741824;
			3'b1_01: c = 33'sd1030695729;
			3'b1_10: c = 33'sd313395603;
			default: c = '0;
		endcase
		return c;
	endfunction

	function automatic logic [MAG_W-1:0] mag_acc(input logic signed [ACC_W-1:0] x);
		logic [ACC_W-1:0] n;
		n = x[ACC_W-1] ? -x : x;
		return n[MAG_W-1:0];
	endfunction

endpackage

### rtl/sgk_front.sv
// sgk_front: configuration registers and sample intake; forms the centre
// distance per axis and flags samples outside the support; uses sgk_pkg
`timescale 1ns / 1ps

module sgk_front #(
	parameter int MAX_SUPPORT = sgk_pkg::DEF_MAX_SUPPORT,
	parameter int MAX_OVERSAMPLING = sgk_pkg::DEF_MAX_OVERSAMPLING
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_write,
	input  logic                        cfg_index,
	input  logic [sgk_pkg::CFG_W-1:0]   cfg_data,
	input  logic                        sample_valid,
	output logic                        sample_stall,
	input  logic [sgk_pkg::IDX_W-1:0]   column_index,
	input  logic [sgk_pkg::IDX_W-1:0]   row_index,
	input  sgk_pkg::sgk_qstat_t         qstat,
	output logic                        push,
	output sgk_pkg::sgk_item_t          item
);
	import sgk_pkg::*;

	logic [S_W-1:0] support_q;
	logic [O_W-1:0] oversamp_q;
	logic [S_W-1:0] s_new;
	logic [O_W-1:0] o_new;
	logic [DEN_W-1:0] den;

	always_comb begin
		s_new = cfg_data[S_W-1:0];
		if (s_new == '0) begin
			s_new = S_W'(1);
		end else if (32'(s_new) > MAX_SUPPORT) begin
			s_new = S_W'(MAX_SUPPORT);
		end
		o_new = cfg_data[O_W-1:0];
		if (o_new == '0) begin
			o_new = O_W'(1);
		end else if (32'(o_new) > MAX_OVERSAMPLING) begin
			o_new = O_W'(MAX_OVERSAMPLING);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			support_q <= SUPPORT_RESET;
			oversamp_q <= OVERSAMPLING_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_SUPPORT:      support_q <= s_new;
				REG_OVERSAMPLING: oversamp_q <= o_new;
				default: ;
			endcase
		end
	end

	assign den = DEN_W'(support_q) * DEN_W'(oversamp_q);
	assign sample_stall = qstat.full;
	assign push = sample_valid && !qstat.full;

	always_comb begin
		item.den = den;
		item.ad_x = (column_index >= den) ? column_index - den : den - column_index;
		item.ad_y = (row_index >= den) ? row_index - den : den - row_index;
		item.out_x = item.ad_x > den;
		item.out_y = item.ad_y > den;
	end

endmodule

### rtl/sgk_queue.sv
// sgk_queue: short word queue between intake and evaluator
// uses sgk_pkg for the word and status types
`timescale 1ns / 1ps

module sgk_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  sgk_pkg::sgk_item_t  wr_item,
	input  logic                pop,
	output sgk_pkg::sgk_item_t  head,
	output sgk_pkg::sgk_qstat_t qstat
);
	import sgk_pkg::*;

	sgk_item_t mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic do_push;
	logic do_pop;

	assign qstat.count = count_q;
	assign qstat.full = count_q == CNT_W'(QUEUE_DEPTH);
	assign qstat.empty = count_q == '0;
	assign do_push = push && !qstat.full;
	assign do_pop = pop && !qstat.empty;
	assign head = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### rtl/sgk_axis.sv
// sgk_axis: one-axis spheroidal evaluator pipeline: distance divider, square,
// rational Horner steps, quotient divider and taper multiply; uses sgk_pkg
`timescale 1ns / 1ps

module sgk_axis (
	input  logic                      clk,
	input  logic                      en,
	input  logic [sgk_pkg::DEN_W-1:0] ad,
	input  logic [sgk_pkg::DEN_W-1:0] den,
	input  logic                      outside,
	output logic [sgk_pkg::AX_W-1:0]  ax
);
	import sgk_pkg::*;

	// distance divider: nu = (ad * 2^17 + den) / (2 * den)
	logic [DEN_W:0]   r1_s  [0:NUQ_W];
	logic [NUQ_W-1:0] lo1_s [0:NUQ_W];
	logic [NUQ_W-1:0] q1_s  [0:NUQ_W];
	logic [DEN_W:0]   d1_s  [0:NUQ_W];
	logic             o1_s  [0:NUQ_W];

	always_ff @(posedge clk) begin
		if (en) begin
			r1_s[0] <= {1'b0, ad};
			lo1_s[0] <= NUQ_W'(den);
			q1_s[0] <= '0;
			d1_s[0] <= {den, 1'b0};
			o1_s[0] <= outside;
		end
	end

	for (genvar i = 0; i < NUQ_W; i++) begin : g_div1
		logic [DEN_W+1:0] t;
		logic ge;
		assign t = {r1_s[i], lo1_s[i][NUQ_W-1]};
		assign ge = t >= {1'b0, d1_s[i]};
		always_ff @(posedge clk) begin
			if (en) begin
				r1_s[i+1] <= ge ? (DEN_W+1)'(t - {1'b0, d1_s[i]}) : t[DEN_W:0];
				q1_s[i+1] <= {q1_s[i][NUQ_W-2:0], ge};
				lo1_s[i+1] <= {lo1_s[i][NUQ_W-2:0], 1'b0};
				d1_s[i+1] <= d1_s[i];
				o1_s[i+1] <= o1_s[i];
			end
		end
	end

	logic [NUSQ_W-1:0] nusq_s19;
	logic              seg_s19;
	logic              out_s19;

	always_ff @(posedge clk) begin
		if (en) begin
			nusq_s19 <= NUSQ_W'(q1_s[NUQ_W]) * NUSQ_W'(q1_s[NUQ_W]);
			seg_s19 <= q1_s[NUQ_W] >= SEG_SPLIT;
			out_s19 <= o1_s[NUQ_W];
		end
	end

	// horner state after each step; index 0 is the start value
	logic signed [ACC_W-1:0] top_h [0:4];
	logic signed [ACC_W-1:0] bot_h [0:4];
	logic [MAG_W-1:0]        dqm_h [0:4];
	logic [NUSQ_W-1:0]       omn_h [0:4];
	logic                    seg_h [0:4];
	logic                    out_h [0:4];
	logic [NUSQ_W-1:0]       dq_full;

	assign dq_full = (seg_s19 ? ONE_Q32 : SEG0_OFFSET) - nusq_s19;

	always_ff @(posedge clk) begin
		if (en) begin
			dqm_h[0] <= dq_full[MAG_W-1:0];
			omn_h[0] <= ONE_Q32 - nusq_s19;
			seg_h[0] <= seg_s19;
			out_h[0] <= out_s19;
			top_h[0] <= num_coef(seg_s19, 3'd4);
			bot_h[0] <= den_coef(seg_s19, 2'd2);
		end
	end

	for (genvar j = 0; j < 4; j++) begin : g_horner
		logic [2*MAG_W-1:0]      pt_m;
		logic [2*MAG_W-1:0]      pb_m;
		logic                    tn_m;
		logic                    bn_m;
		logic signed [ACC_W-1:0] bot_m;
		logic [MAG_W-1:0]        dqm_m;
		logic [NUSQ_W-1:0]       omn_m;
		logic                    seg_m;
		logic                    out_m;
		logic [2*MAG_W:0]        st;
		logic [2*MAG_W:0]        sb;
		logic signed [ACC_W-1:0] ct;
		logic signed [ACC_W:0]   nt;
		logic signed [ACC_W:0]   nb;

		always_ff @(posedge clk) begin
			if (en) begin
				pt_m <= (2*MAG_W)'(dqm_h[j]) * (2*MAG_W)'(mag_acc(top_h[j]));
				pb_m <= (2*MAG_W)'(dqm_h[j]) * (2*MAG_W)'(mag_acc(bot_h[j]));
				tn_m <= top_h[j][ACC_W-1];
				bn_m <= bot_h[j][ACC_W-1];
				bot_m <= bot_h[j];
				dqm_m <= dqm_h[j];
				omn_m <= omn_h[j];
				seg_m <= seg_h[j];
				out_m <= out_h[j];
			end
		end

		// dq is never negative and the step uses -dq, so the product sign is the opposite of acc
		always_comb begin
			st = {1'b0, pt_m} + (2*MAG_W+1)'(33'h0_8000_0000);
			sb = {1'b0, pb_m} + (2*MAG_W+1)'(33'h0_8000_0000);
			ct = num_coef(seg_m, 3'(3 - j));
			nt = tn_m ? $signed({ct[ACC_W-1], ct}) + $signed({2'b00, st[2*MAG_W-1:MAG_W]})
			          : $signed({ct[ACC_W-1], ct}) - $signed({2'b00, st[2*MAG_W-1:MAG_W]});
			if (j >= 2) begin
				nb = bn_m
				   ? $signed({den_coef(seg_m, 2'(3 - j)), 1'b0}) / 2
				     + $signed({2'b00, sb[2*MAG_W-1:MAG_W]})
				   : $signed({den_coef(seg_m, 2'(3 - j)), 1'b0}) / 2
				     - $signed({2'b00, sb[2*MAG_W-1:MAG_W]});
			end else begin
				nb = $signed({bot_m[ACC_W-1], bot_m});
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				top_h[j+1] <= nt[ACC_W-1:0];
				bot_h[j+1] <= nb[ACC_W-1:0];
				dqm_h[j+1] <= dqm_m;
				omn_h[j+1] <= omn_m;
				seg_h[j+1] <= seg_m;
				out_h[j+1] <= out_m;
			end
		end
	end

	// quotient divider: psi = (|top| * 2^30 + bot / 2) / bot
	logic [MAG_W-1:0]   r2_s   [0:MAG_W];
	logic [MAG_W-1:0]   lo2_s  [0:MAG_W];
	logic [MAG_W-1:0]   q2_s   [0:MAG_W];
	logic [MAG_W-1:0]   b2_s   [0:MAG_W];
	logic               ng2_s  [0:MAG_W];
	logic               o2_s   [0:MAG_W];
	logic [NUSQ_W-1:0]  omn2_s [0:MAG_W];
	logic [MAG_W-1:0]   botc;
	logic [2*MAG_W-1:0] nn;

	always_comb begin
		botc = (bot_h[4] < $signed(33'sd1)) ? MAG_W'(1) : bot_h[4][MAG_W-1:0];
		nn = {2'b00, mag_acc(top_h[4]), 30'd0} + {MAG_W'(0), 1'b0, botc[MAG_W-1:1]};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r2_s[0] <= nn[2*MAG_W-1:MAG_W];
			lo2_s[0] <= nn[MAG_W-1:0];
			q2_s[0] <= '0;
			b2_s[0] <= botc;
			ng2_s[0] <= top_h[4][ACC_W-1];
			o2_s[0] <= out_h[4];
			omn2_s[0] <= omn_h[4];
		end
	end

	for (genvar i = 0; i < MAG_W; i++) begin : g_div2
		logic [MAG_W:0] t;
		logic ge;
		assign t = {r2_s[i], lo2_s[i][MAG_W-1]};
		assign ge = t >= {1'b0, b2_s[i]};
		always_ff @(posedge clk) begin
			if (en) begin
				r2_s[i+1] <= ge ? MAG_W'(t - {1'b0, b2_s[i]}) : t[MAG_W-1:0];
				q2_s[i+1] <= {q2_s[i][MAG_W-2:0], ge};
				lo2_s[i+1] <= {lo2_s[i][MAG_W-2:0], 1'b0};
				b2_s[i+1] <= b2_s[i];
				ng2_s[i+1] <= ng2_s[i];
				o2_s[i+1] <= o2_s[i];
				omn2_s[i+1] <= omn2_s[i];
			end
		end
	end

	logic [NUSQ_W+MAG_W-1:0] pr_s62;
	logic                    z_s62;
	logic [NUSQ_W+MAG_W:0]   rnd;

	always_ff @(posedge clk) begin
		if (en) begin
			pr_s62 <= (NUSQ_W+MAG_W)'(omn2_s[MAG_W]) * (NUSQ_W+MAG_W)'(q2_s[MAG_W]);
			z_s62 <= o2_s[MAG_W] || ng2_s[MAG_W];
		end
	end

	assign rnd = {1'b0, pr_s62} + (NUSQ_W+MAG_W+1)'(33'h0_8000_0000);

	always_ff @(posedge clk) begin
		if (en) begin
			ax <= z_s62 ? '0 : rnd[MAG_W+AX_W-1:MAG_W];
		end
	end

endmodule

### rtl/sgk_back.sv
// sgk_back: evaluator back end: two axis pipelines, separable product,
// rounding and saturation, output word register; uses sgk_pkg, sgk_axis
`timescale 1ns / 1ps

module sgk_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  sgk_pkg::sgk_item_t        head,
	input  logic                      q_empty,
	output logic                      pop,
	output logic                      kernel_valid,
	input  logic                      kernel_stall,
	output logic [sgk_pkg::VAL_W-1:0] kernel_value
);
	import sgk_pkg::*;

	logic adv;
	logic [AXIS_LAT+1:0] vld_q;
	logic [AX_W-1:0] ax;
	logic [AX_W-1:0] ay;
	logic [2*AX_W-1:0] prod_s64;
	logic [2*AX_W:0] rnd;
	logic [2*AX_W-37:0] scaled;

	assign kernel_valid = vld_q[AXIS_LAT+1];
	assign adv = !kernel_valid || !kernel_stall;
	assign pop = adv && !q_empty;

	sgk_axis u_axis_x (
		.clk     (clk),
		.en      (adv),
		.ad      (head.ad_x),
		.den     (head.den),
		.outside (head.out_x),
		.ax      (ax)
	);

	sgk_axis u_axis_y (
		.clk     (clk),
		.en      (adv),
		.ad      (head.ad_y),
		.den     (head.den),
		.outside (head.out_y),
		.ax      (ay)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[AXIS_LAT:0], pop};
		end
	end

	// axis values stay at or below 2^31, so the top carry bit is always clear
	assign rnd = {1'b0, prod_s64} + (2*AX_W+1)'(37'h8_0000_0000);
	assign scaled = rnd[2*AX_W-1:36];

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s64 <= (2*AX_W)'(ax) * (2*AX_W)'(ay);
			kernel_value <= (scaled > (2*AX_W-36)'(VAL_MAX)) ? VAL_MAX : scaled[VAL_W-1:0];
		end
	end

endmodule

### rtl/spheroidal_gridding_kernel_core.sv
// spheroidal_gridding_kernel_core: top level of the gridding kernel evaluator
// depends on sgk_pkg, sgk_front, sgk_queue, sgk_back
`timescale 1ns / 1ps

// Usage
//   sample channel: column_index/row_index words under sample_valid/sample_stall
//   kernel channel: kernel_value words under kernel_valid/kernel_stall
//   config port: cfg_write, cfg_index (0 support, 1 oversampling), cfg_data;
//   write only while no word is in flight
// Throughput: one sample word per cycle, sustained while the kernel channel is not stalled
// Path: a taken sample word passes through the queue, then the evaluator with
//   the 17 step distance divider, eight Horner stages and the 32 step
//   quotient divider
// Reset: registers return to support 7 and oversampling 128; queue and
//   evaluator are emptied, no kernel word is valid
// Stall: while kernel_stall holds a valid word the whole evaluator freezes;
//   the four word queue keeps taking samples until full, then sample_stall
//   rises; words are never dropped or repeated
module spheroidal_gridding_kernel_core #(
	parameter int MAX_SUPPORT = sgk_pkg::DEF_MAX_SUPPORT,
	parameter int MAX_OVERSAMPLING = sgk_pkg::DEF_MAX_OVERSAMPLING
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_write,
	input  logic                      cfg_index,
	input  logic [sgk_pkg::CFG_W-1:0] cfg_data,
	input  logic                      sample_valid,
	output logic                      sample_stall,
	input  logic [sgk_pkg::IDX_W-1:0] column_index,
	input  logic [sgk_pkg::IDX_W-1:0] row_index,
	output logic                      kernel_valid,
	input  logic                      kernel_stall,
	output logic [sgk_pkg::VAL_W-1:0] kernel_value
);
	import sgk_pkg::*;

	sgk_qstat_t qstat;
	sgk_item_t  wr_item;
	sgk_item_t  head;
	logic       push;
	logic       pop;

	sgk_front #(
		.MAX_SUPPORT      (MAX_SUPPORT),
		.MAX_OVERSAMPLING (MAX_OVERSAMPLING)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.column_index (column_index),
		.row_index    (row_index),
		.qstat        (qstat),
		.push         (push),
		.item         (wr_item)
	);

	sgk_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_item (wr_item),
		.pop     (pop),
		.head    (head),
		.qstat   (qstat)
	);

	sgk_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.q_empty      (qstat.empty),
		.pop          (pop),
		.kernel_valid (kernel_valid),
		.kernel_stall (kernel_stall),
		.kernel_value (kernel_value)
	);

`ifndef SYNTHESIS
	a_value_saturated: assert property (@(posedge clk) disable iff (!arst_n)
		kernel_valid |-> kernel_value <= VAL_MAX)
		else $error("kernel word above 1.0");

	a_taken_word_queued: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && !sample_stall |=> !qstat.empty)
		else $error("accepted sample word missing from queue");

	a_frozen_no_pop: assert property (@(posedge clk) disable iff (!arst_n)
		kernel_valid && kernel_stall |-> !pop)
		else $error("queue popped while evaluator frozen");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		qstat.count <= CNT_W'(QUEUE_DEPTH))
		else $error("queue count beyond depth");
`endif

endmodule
